// ===== rtl/word_find_and_replace_defines.svh =====
// Assertion macros shared by the word find-and-replace RTL.
// Expects i_clk and the synchronous active-low i_rst_n in the including module.
`ifndef WORD_FIND_AND_REPLACE_DEFINES_SVH
`define WORD_FIND_AND_REPLACE_DEFINES_SVH

// Same-cycle implication, ignored while in reset
`define WFR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while in reset
`define WFR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/wfr_pkg.sv =====
// Types and constants for the word find-and-replace block.
// No dependencies; imported by every module of the block.
`default_nettype none

package wfr_pkg;

    // Bytes held by a search or replacement word register
    localparam int WORD_BYTES = 8;
    localparam int BYTE_IW    = $clog2(WORD_BYTES);

    // Delimiter characters
    localparam logic [7:0] SPACE_CHAR   = 8'h20;
    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

    // Configuration register indexes
    localparam logic [2:0] REG_CASE_SENSITIVE = 3'd0;
    localparam logic [2:0] REG_SEARCH_WORD    = 3'd1;
    localparam logic [2:0] REG_SEARCH_LENGTH  = 3'd2;
    localparam logic [2:0] REG_REPL_WORD      = 3'd3;
    localparam logic [2:0] REG_REPL_LENGTH    = 3'd4;

    // Job queue between front and back
    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [7:0] text_byte;
        logic       flush_only;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
    } t_out_item;

    typedef struct packed {
        logic        case_sensitive;
        logic [63:0] search_word;
        logic [3:0]  search_length;
        logic [63:0] replacement_word;
        logic [3:0]  replacement_length;
    } t_cfg;

    // One burst of output bytes caused by a single input transaction
    typedef struct packed {
        logic [WORD_BYTES-1:0][7:0] bytes;
        logic [3:0]                 count;
    } t_job;

    // Queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

`default_nettype wire

// ===== rtl/word_find_and_replace.sv =====
// Top level of the word find-and-replace block: configuration registers and wiring.
// Depends on wfr_pkg, wfr_front, wfr_queue and wfr_back.
//
//  channel | direction | payload      | handshake
//  --------+-----------+--------------+------------------------------
//  in      | input     | t_in_item    | i_in_valid / o_in_stall
//  out     | output    | t_out_item   | o_out_valid / i_out_stall
//  cfg     | input     | 64-bit data  | i_cfg_we, i_cfg_index
//
// The front end takes one input transaction per cycle while the job queue has room.
// An input causing n results (0 to 8) occupies the output serialiser for n bytes,
// one byte per cycle unless the output stalls; the output port sets the sustained rate.
// Reset is synchronous; no clearing pass, the block accepts input straight after reset.
// Output stalls back up through the two-entry job queue to o_in_stall.
`default_nettype none

module word_find_and_replace
    import wfr_pkg::*;
#(
    parameter int MAX_WORD = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_in_valid,
    input  wire t_in_item    i_in_data,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_item        o_out_data
);

    logic        r_case_sensitive;
    logic [63:0] r_search_word;
    logic [3:0]  r_search_length;
    logic [63:0] r_repl_word;
    logic [3:0]  r_repl_length;

    t_cfg      cfg;
    t_job      push_job;
    t_job      pop_job;
    t_q_status q_status;
    logic      push;
    logic      pop;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_case_sensitive <= 1'b1;
            r_search_word    <= '0;
            r_search_length  <= 4'd1;
            r_repl_word      <= '0;
            r_repl_length    <= 4'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_CASE_SENSITIVE: r_case_sensitive <= i_cfg_data[0];
                REG_SEARCH_WORD:    r_search_word    <= i_cfg_data;
                REG_SEARCH_LENGTH:  r_search_length  <= i_cfg_data[3:0];
                REG_REPL_WORD:      r_repl_word      <= i_cfg_data;
                REG_REPL_LENGTH:    r_repl_length    <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign cfg.case_sensitive     = r_case_sensitive;
    assign cfg.search_word        = r_search_word;
    assign cfg.search_length      = r_search_length;
    assign cfg.replacement_word   = r_repl_word;
    assign cfg.replacement_length = r_repl_length;

    wfr_front #(
        .MAX_WORD (MAX_WORD)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_q_status (q_status),
        .o_push     (push),
        .o_job      (push_job)
    );

    wfr_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_job    (pop_job),
        .o_status (q_status)
    );

    wfr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (pop_job),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ===== rtl/wfr_front.sv =====
// Front end: accepts text transactions, keeps the match window and builds output jobs.
// Depends on wfr_pkg.
`default_nettype none

module wfr_front
    import wfr_pkg::*;
#(
    parameter int MAX_WORD = 8
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cfg      i_cfg,
    input  wire logic      i_in_valid,
    input  wire t_in_item  i_in_data,
    output logic           o_in_stall,
    input  wire t_q_status i_q_status,
    output logic           o_push,
    output t_job           o_job
);

    localparam int FW = $clog2(MAX_WORD + 1);

    logic [7:0]    r_win [MAX_WORD];
    logic [FW-1:0] r_fill;

    logic [7:0]    a_win [MAX_WORD];
    logic [7:0]    n_win [MAX_WORD];
    logic [FW-1:0] a_fill;
    logic [FW-1:0] n_fill;
    logic [FW-1:0] len;
    logic [FW-1:0] sh;
    logic [3:0]    len4;
    logic [3:0]    rlen;
    logic          in_acc;
    logic          is_delim;
    logic          full;
    logic          hit;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'h20;
        end
        return c;
    endfunction

    assign o_in_stall = i_q_status.full;
    assign in_acc     = i_in_valid && !i_q_status.full;

    // Classify the transaction and work out the window update and output job
    always_comb begin
        // effective search length, clamped to 1..MAX_WORD
        if (i_cfg.search_length == 4'd0) begin
            len4 = 4'd1;
        end else if (i_cfg.search_length > 4'(MAX_WORD)) begin
            len4 = 4'(MAX_WORD);
        end else begin
            len4 = i_cfg.search_length;
        end
        len  = FW'(len4);
        rlen = (i_cfg.replacement_length > 4'(WORD_BYTES)) ? 4'(WORD_BYTES)
                                                           : i_cfg.replacement_length;

        is_delim = (i_in_data.text_byte == SPACE_CHAR) ||
                   (i_in_data.text_byte == NEWLINE_CHAR);

        // window with the new byte appended
        a_win  = r_win;
        for (int i = 0; i < MAX_WORD; i++) begin
            if (FW'(i) == r_fill) begin
                a_win[i] = i_in_data.text_byte;
            end
        end
        a_fill = (r_fill < FW'(MAX_WORD)) ? r_fill + FW'(1) : r_fill;
        full   = (a_fill >= len);

        // compare the oldest len bytes with the search word
        hit = 1'b1;
        for (int i = 0; i < MAX_WORD; i++) begin
            if (FW'(i) < len) begin
                if (i_cfg.case_sensitive) begin
                    if (a_win[i] != i_cfg.search_word[8*i +: 8]) begin
                        hit = 1'b0;
                    end
                end else begin
                    if (fold_case(a_win[i]) != fold_case(i_cfg.search_word[8*i +: 8])) begin
                        hit = 1'b0;
                    end
                end
            end
        end

        // drop the matched word or the oldest byte
        sh    = hit ? len : FW'(1);
        n_win = a_win;
        for (int i = 0; i < MAX_WORD; i++) begin
            for (int j = 1; j <= MAX_WORD; j++) begin
                if (i + j < MAX_WORD) begin
                    if (FW'(j) == sh) begin
                        n_win[i] = a_win[i + j];
                    end
                end
            end
        end
        n_fill = a_fill - sh;

        // output job
        o_job.bytes = '0;
        o_job.count = 4'd0;
        if (i_in_data.flush_only) begin
            for (int i = 0; i < MAX_WORD; i++) begin
                o_job.bytes[i] = r_win[i];
            end
            o_job.count = 4'(r_fill);
        end else if (is_delim) begin
            for (int i = 0; i < MAX_WORD; i++) begin
                o_job.bytes[i] = a_win[i];
            end
            o_job.count = 4'(r_fill) + 4'd1;
        end else if (full) begin
            if (hit) begin
                o_job.bytes = i_cfg.replacement_word;
                o_job.count = rlen;
            end else begin
                o_job.bytes[0] = a_win[0];
                o_job.count    = 4'd1;
            end
        end

        o_push = in_acc && (o_job.count != 4'd0);
    end

    // Window fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (in_acc) begin
            if (i_in_data.flush_only || is_delim) begin
                r_fill <= '0;
            end else if (full) begin
                r_fill <= n_fill;
            end else begin
                r_fill <= a_fill;
            end
        end
    end

    // Window bytes
    always_ff @(posedge i_clk) begin
        if (in_acc && !i_in_data.flush_only && !is_delim) begin
            if (full) begin
                r_win <= n_win;
            end else begin
                r_win <= a_win;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/wfr_queue.sv =====
// Short job queue that decouples the front end from the output serialiser.
// Depends on wfr_pkg and word_find_and_replace_defines.svh.
`default_nettype none
`include "word_find_and_replace_defines.svh"

module wfr_queue
    import wfr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output t_job      o_job,
    output t_q_status o_status
);

    t_job           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QCW-1:0] r_cnt;

    assign o_status.full  = (r_cnt == QCW'(QDEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign o_job          = r_mem[r_rd];

    // Pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QAW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QAW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QCW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - QCW'(1);
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    `WFR_ASSERT_IMP(a_no_push_full, o_status.full, !i_push, "push into full job queue")
    `WFR_ASSERT_IMP(a_no_pop_empty, o_status.empty, !i_pop, "pop from empty job queue")

endmodule

`default_nettype wire

// ===== rtl/wfr_back.sv =====
// Back end: takes jobs from the queue and sends their bytes one per cycle unless the output stalls.
// Depends on wfr_pkg and word_find_and_replace_defines.svh.
`default_nettype none
`include "word_find_and_replace_defines.svh"

module wfr_back
    import wfr_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_job      i_job,
    input  wire t_q_status i_q_status,
    output logic           o_pop,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_data
);

    t_job      r_job;
    logic [3:0] r_idx;
    logic      r_busy;
    logic      r_ov;
    t_out_item r_out;

    logic adv;
    logic last;
    logic load;

    assign adv  = r_busy && (!r_ov || !i_out_stall);
    assign last = (r_idx + 4'd1 == r_job.count);
    assign load = !i_q_status.empty && (!r_busy || (adv && last));

    assign o_pop       = load;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    // Serialiser control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 4'd0;
            r_ov   <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
                r_idx  <= 4'd0;
            end else if (adv) begin
                r_idx <= r_idx + 4'd1;
                if (last) begin
                    r_busy <= 1'b0;
                end
            end
            if (adv) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Job and output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_job;
        end
        if (adv) begin
            r_out.out_byte <= r_job.bytes[r_idx[BYTE_IW-1:0]];
            r_out.run_end  <= last;
        end
    end

    `WFR_ASSERT_IMP(a_busy_count, r_busy, r_job.count != 4'd0, "empty job in serialiser")
    `WFR_ASSERT_IMP(a_idx_range, r_busy, r_idx < r_job.count, "byte index past job end")

endmodule

`default_nettype wire

// ===== sim/wfr_rewrite_checker.sv =====
`timescale 1ns / 1ps
// Checker for the word find-and-replace block: watches the config, input and output
// channels, predicts the rewritten byte stream and compares it. Depends on wfr_pkg.
module wfr_rewrite_checker
    import wfr_pkg::*;
#(
    parameter int MAX_WORD = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in_item    i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out_item   i_out_data,
    output int          o_fail_count,
    output int          o_pending
);

    // Shadow copy of the configuration registers
    logic        exact_q;
    logic [63:0] find_word_q;
    logic [3:0]  find_len_q;
    logic [63:0] subst_word_q;
    logic [3:0]  subst_len_q;

    // Candidate window, oldest byte at index 0
    logic [7:0]  window_q [MAX_WORD];
    int unsigned window_fill;

    logic [7:0]  burst_bytes [$];
    t_out_item   expected_bytes [$];
    int          fail_total = 0;

    assign o_fail_count = fail_total;

    task automatic report_mismatch(input string what);
        $display("[%0t] rewrite mismatch: %s", $time, what);
        fail_total++;
    endtask

    function automatic logic [7:0] fold_letter(input logic [7:0] c, input logic fold);
        if (fold && c >= 8'h41 && c <= 8'h5A)
            return c + 8'h20;
        return c;
    endfunction

    // Window contents go out in order; window empties
    task automatic spill_window();
        int unsigned i;
        for (i = 0; i < window_fill && i < MAX_WORD; i++)
            burst_bytes.push_back(window_q[i]);
        window_fill = 0;
    endtask

    task automatic drop_front(input int unsigned n);
        int unsigned i;
        if (n > window_fill)
            n = window_fill;
        for (i = 0; i + n < window_fill; i++)
            window_q[i] = window_q[i + n];
        window_fill = window_fill - n;
    endtask

    // Expected output bytes for one input transaction
    task automatic rewrite_item(input t_in_item item);
        int unsigned find_len;
        int unsigned subst_len;
        int unsigned i;
        logic        hit;
        t_out_item   res;
        burst_bytes.delete();
        find_len = (find_len_q == 0) ? 1 : ((find_len_q > MAX_WORD) ? MAX_WORD : find_len_q);
        if (item.flush_only) begin
            spill_window();
        end else if (item.text_byte == SPACE_CHAR || item.text_byte == NEWLINE_CHAR) begin
            spill_window();
            burst_bytes.push_back(item.text_byte);
        end else begin
            if (window_fill < MAX_WORD) begin
                window_q[window_fill] = item.text_byte;
                window_fill++;
            end
            if (window_fill >= find_len) begin
                hit = 1'b1;
                for (i = 0; i < find_len; i++)
                    if (fold_letter(window_q[i], !exact_q) !=
                        fold_letter(find_word_q[8*i +: 8], !exact_q))
                        hit = 1'b0;
                if (hit) begin
                    subst_len = (subst_len_q > WORD_BYTES) ? WORD_BYTES : subst_len_q;
                    for (i = 0; i < subst_len; i++)
                        burst_bytes.push_back(subst_word_q[8*i +: 8]);
                    drop_front(find_len);
                end else begin
                    burst_bytes.push_back(window_q[0]);
                    drop_front(1);
                end
            end
        end
        foreach (burst_bytes[j]) begin
            res.out_byte = burst_bytes[j];
            res.run_end  = (j == burst_bytes.size() - 1);
            expected_bytes.push_back(res);
        end
    endtask

    // Monitor: output check first, then prediction, then register writes
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (!i_rst_n) begin
            exact_q      = 1'b1;
            find_word_q  = '0;
            find_len_q   = 4'd1;
            subst_word_q = '0;
            subst_len_q  = '0;
            window_fill  = 0;
            expected_bytes.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %02h run_end %0b",
                                              i_out_data.out_byte, i_out_data.run_end));
                end else begin
                    want = expected_bytes.pop_front();
                    if (i_out_data.out_byte !== want.out_byte)
                        report_mismatch($sformatf("out_byte got %02h want %02h",
                                                  i_out_data.out_byte, want.out_byte));
                    if (i_out_data.run_end !== want.run_end)
                        report_mismatch($sformatf("run_end got %0b want %0b (byte %02h)",
                                                  i_out_data.run_end, want.run_end,
                                                  want.out_byte));
                end
            end
            if (i_in_valid && !i_in_stall)
                rewrite_item(i_in_data);
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_CASE_SENSITIVE: exact_q      = i_cfg_data[0];
                    REG_SEARCH_WORD:    find_word_q  = i_cfg_data;
                    REG_SEARCH_LENGTH:  find_len_q   = i_cfg_data[3:0];
                    REG_REPL_WORD:      subst_word_q = i_cfg_data;
                    REG_REPL_LENGTH:    subst_len_q  = i_cfg_data[3:0];
                    default: ;
                endcase
            end
        end
        o_pending <= expected_bytes.size();
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for word_find_and_replace: clock, reset, config, stimulus and verdict.
// Depends on wfr_pkg, the block RTL and wfr_rewrite_checker.
module tb;
    import wfr_pkg::*;

    localparam int MAX_WORD        = 8;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 16;
    localparam int RAND_PHASES     = 9;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int LONG_HOLD       = 300;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_we      = 1'b0;
    logic [2:0]  cfg_index   = REG_CASE_SENSITIVE;
    logic [63:0] cfg_data    = '0;
    logic        in_valid    = 1'b0;
    t_in_item    in_data     = '0;
    logic        in_stall;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    t_out_item   out_data;

    int          fail_count;
    int          pending;
    bit          idle_on     = 1'b1;
    int          long_hold   = 0;
    string       alphabet    = "aAbB";

    // 8 ns clock
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    word_find_and_replace #(
        .MAX_WORD(MAX_WORD)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .i_in_data  (in_data),
        .o_in_stall (in_stall),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    wfr_rewrite_checker #(
        .MAX_WORD(MAX_WORD)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    function automatic logic [63:0] pack_word(input string s);
        logic [63:0] w;
        w = '0;
        for (int i = 0; i < s.len() && i < WORD_BYTES; i++)
            w[8*i +: 8] = s[i];
        return w;
    endfunction

    // One input transaction, after a random idle gap while idle_on is set
    task automatic send_item(input logic [7:0] text, input logic flush);
        int       gap;
        t_in_item item;
        gap = idle_on ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.text_byte = text;
        item.flush_only = flush;
        in_data  <= item;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    // Wait for every expected byte, then let the block go quiet
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Narrow registers get random upper bits, which must be ignored
    task automatic write_config(input logic exact, input logic [63:0] find_word,
                                input logic [3:0] find_len, input logic [63:0] subst_word,
                                input logic [3:0] subst_len);
        logic [63:0] d;
        d = {$urandom, $urandom};
        d[0] = exact;
        cfg_write(REG_CASE_SENSITIVE, d);
        cfg_write(REG_SEARCH_WORD, find_word);
        d = {$urandom, $urandom};
        d[3:0] = find_len;
        cfg_write(REG_SEARCH_LENGTH, d);
        cfg_write(REG_REPL_WORD, subst_word);
        d = {$urandom, $urandom};
        d[3:0] = subst_len;
        cfg_write(REG_REPL_LENGTH, d);
        cfg_we <= 1'b0;
    endtask

    // Output side: random readiness, one long hold when asked
    initial begin : receiver
        int hold;
        forever begin
            if (long_hold > 0) begin
                hold = long_hold;
                long_hold = 0;
            end else begin
                hold = idle_on ? $urandom_range(0, 17) : 0;
            end
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Watchdog: too long without any transaction on either channel
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb NOT OK");
        $finish;
    end

    initial begin : stimulus
        logic        exact;
        logic [3:0]  find_len;
        logic [3:0]  subst_len;
        logic [63:0] find_word;
        logic [63:0] subst_word;
        logic [7:0]  b;
        int          eff_len;
        int          run;
        int          pick;
        int          sent;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: search for 0x00, zero replacement deletes the match
        send_item(8'h00, 1'b0);
        // flush with an empty window
        send_item(8'hA5, 1'b1);

        // Case-insensitive match, extreme byte held then released by newline
        settle();
        write_config(1'b0, pack_word("cat"), 4'd3, pack_word("DOG"), 4'd3);
        send_text("CaT");
        send_item(8'hFF, 1'b0);
        send_item(NEWLINE_CHAR, 1'b0);
        send_text("c");
        send_item(8'h00, 1'b1);

        // Delimiter inside the search word never matches
        settle();
        write_config(1'b1, pack_word("a b"), 4'd3, pack_word("zz"), 4'd2);
        send_text("a ");

        // Search length lowered with bytes in the window; oversized replacement length
        settle();
        subst_word = 64'h0123_4567_89AB_CDEF;
        write_config(1'b1, pack_word("hello"), 4'd5, subst_word, 4'd12);
        send_text("hel");
        settle();
        write_config(1'b1, pack_word("hello"), 4'd2, subst_word, 4'd12);
        send_text("x");
        send_item(8'h5A, 1'b1);

        // Search length zero acts as one
        settle();
        write_config(1'b0, pack_word("hello"), 4'd0, subst_word, 4'd12);
        send_text("H");

        // Search length above the maximum acts as the maximum
        settle();
        write_config(1'b1, pack_word("abcdefgh"), 4'd15, '1, 4'd8);
        send_text("abcdefgh");

        // Random phases: mostly (near-)occurrences of the word, plus noise
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            settle();
            idle_on = (phase % 3) != 1;
            if (phase == 4)
                long_hold = LONG_HOLD;
            exact = $urandom_range(0, 1);
            find_len = 4'($urandom_range(1, MAX_WORD));
            pick = $urandom_range(0, 9);
            if (pick == 0)
                find_len = 4'd0;
            else if (pick == 1)
                find_len = 4'($urandom_range(MAX_WORD + 1, 15));
            subst_len = 4'($urandom_range(0, WORD_BYTES));
            if ($urandom_range(0, 9) == 0)
                subst_len = 4'($urandom_range(WORD_BYTES + 1, 15));
            if (phase == 0) begin
                find_len  = 4'(MAX_WORD);
                subst_len = 4'(WORD_BYTES);
            end else if (phase == 1) begin
                find_len  = 4'd1;
                subst_len = 4'd0;
            end
            for (int k = 0; k < WORD_BYTES; k++)
                find_word[8*k +: 8] = ($urandom_range(0, 6) == 0) ? 8'($urandom)
                                                                  : alphabet[$urandom_range(0, 3)];
            subst_word = {$urandom, $urandom};
            write_config(exact, find_word, find_len, subst_word, subst_len);
            eff_len = (find_len == 0) ? 1 : ((find_len > MAX_WORD) ? MAX_WORD : find_len);

            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    // whole word or a prefix, letters sometimes case-flipped
                    run = (pick < 45) ? eff_len : $urandom_range(1, eff_len);
                    for (int k = 0; k < run; k++) begin
                        b = find_word[8*k +: 8];
                        if ((b | 8'h20) >= 8'h61 && (b | 8'h20) <= 8'h7A &&
                            $urandom_range(0, 3) == 0)
                            b ^= 8'h20;
                        send_item(b, 1'b0);
                    end
                    sent += run;
                end else if (pick < 75) begin
                    send_item(alphabet[$urandom_range(0, 3)], 1'b0);
                    sent++;
                end else if (pick < 85) begin
                    send_item($urandom_range(0, 1) ? SPACE_CHAR : NEWLINE_CHAR, 1'b0);
                    sent++;
                end else if (pick < 90) begin
                    send_item(8'($urandom), 1'b1);
                    sent++;
                end else begin
                    send_item(8'($urandom), 1'b0);
                    sent++;
                end
            end
        end

        settle();
        if (fail_count == 0 && pending == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/wfr_pkg.sv
rtl/wfr_front.sv
rtl/wfr_queue.sv
rtl/wfr_back.sv
rtl/word_find_and_replace.sv
sim/wfr_rewrite_checker.sv
sim/tb.sv
